FILE: rtl/bba_pkg.sv
// shared types, codes and helper functions of the bitmap block allocator
package bba_pkg;

	// default number of blocks the bitmap can hold
	localparam int MAX_BLOCKS_DEF = 4096;

	// bits per bitmap memory word and the matching shift
	localparam int WORD_BITS = 64;
	localparam int WORD_SHIFT = 6;

	// command codes
	localparam logic [1:0] CMD_ALLOC = 2'd0;
	localparam logic [1:0] CMD_FREE  = 2'd1;
	localparam logic [1:0] CMD_COUNT = 2'd2;

	// result status codes
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_RANGE = 2'd2;

	// reset value of the block limit register
	localparam logic [12:0] NBLK_RST = 13'd4096;

	// command word
	typedef struct packed {
		logic [1:0]  command;
		logic [11:0] block_index;
	} bba_cmd_t;

	// result word
	typedef struct packed {
		logic [1:0]  status;
		logic [11:0] granted_index;
		logic [12:0] free_total;
	} bba_rsp_t;

	// controller states
	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_DISP,
		S_SCAN_ALLOC,
		S_FIND,
		S_SCAN_COUNT,
		S_FREE_RD,
		S_FREE_WR,
		S_RESULT
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic start;
		logic clr_wr;
		logic scan_rd;
		logic hit_cap;
		logic find_wr;
		logic free_rd;
		logic free_wr;
		logic set_full;
		logic set_range;
		logic acc_en;
		logic load_out;
	} bba_ctl_t;

	// status from datapath to controller
	typedef struct packed {
		logic clr_last;
		logic issue_done;
		logic s1_hit;
		logic s1_last;
		logic s2_last;
		logic lim_zero;
		logic idx_range;
		logic out_free;
	} bba_sts_t;

	// position of the lowest set bit of a byte
	function automatic logic [2:0] lowest8(input logic [7:0] v);
		logic [2:0] pos;
		pos = 3'd0;
		for (int i = 7; i >= 0; i--) begin
			if (v[i]) begin
				pos = 3'(i);
			end
		end
		return pos;
	endfunction

	// number of set bits in a byte
	function automatic logic [3:0] popcount8(input logic [7:0] v);
		logic [3:0] n;
		n = 4'd0;
		for (int i = 0; i < 8; i++) begin
			n = n + 4'(v[i]);
		end
		return n;
	endfunction

endpackage

FILE: rtl/bitmap_block_allocator.sv
// Bitmap free-block allocator, first fit. Each command word gives exactly one result word.
// The bitmap sits in a memory of 64-bit words, one read or one write per cycle, and allocate
// and count walk it one word per cycle through a short read pipeline. Allocate scans up to the
// first word with a free block below the count, reading at most ceil(count/64) words; count
// reads all ceil(count/64) words; free reads and writes back one word, and commands that
// touch nothing go straight to the result. After reset the block clears the bitmap memory,
// one word a cycle, ceil(MAX_BLOCKS/64) words (64 at the default size), and holds cmd_stall
// high meanwhile; block limit writes are taken at any time. A finished result waits in an
// output register, so the next command is accepted while it is still stalled.
module bitmap_block_allocator #(
	parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [12:0]        cfg_data,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  bba_pkg::bba_cmd_t  cmd,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output bba_pkg::bba_rsp_t  rsp
);
	import bba_pkg::*;

	bba_ctl_t ctl;
	bba_sts_t sts;

	// sequencing of each command
	bba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.command   (cmd.command),
		.cmd_stall (cmd_stall),
		.sts       (sts),
		.ctl       (ctl)
	);

	// bitmap storage, scan and result
	bba_dp #(
		.MAX_BLOCKS (MAX_BLOCKS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_data    (cfg_data),
		.block_index (cmd.block_index),
		.ctl         (ctl),
		.sts         (sts),
		.rsp         (rsp),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall)
	);

endmodule

FILE: rtl/bba_ctrl.sv
// controller state machine of the bitmap block allocator
module bba_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	input  logic [1:0]          command,
	output logic                cmd_stall,
	input  bba_pkg::bba_sts_t   sts,
	output bba_pkg::bba_ctl_t   ctl
);
	import bba_pkg::*;

	state_t     state_q;
	state_t     state_nxt;
	logic [1:0] cmd_q;

	// state and latched command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			cmd_q   <= CMD_ALLOC;
		end else begin
			state_q <= state_nxt;
			if (ctl.start) begin
				cmd_q <= command;
			end
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_CLEAR: begin
				if (sts.clr_last) begin
					state_nxt = S_IDLE;
				end
			end
			S_IDLE: begin
				if (cmd_valid) begin
					state_nxt = S_DISP;
				end
			end
			S_DISP: begin
				case (cmd_q)
					CMD_ALLOC: state_nxt = sts.lim_zero ? S_RESULT : S_SCAN_ALLOC;
					CMD_FREE:  state_nxt = sts.idx_range ? S_RESULT : S_FREE_RD;
					CMD_COUNT: state_nxt = sts.lim_zero ? S_RESULT : S_SCAN_COUNT;
					default:   state_nxt = S_RESULT;
				endcase
			end
			S_SCAN_ALLOC: begin
				if (sts.s1_hit) begin
					state_nxt = S_FIND;
				end else if (sts.s1_last) begin
					state_nxt = S_RESULT;
				end
			end
			S_FIND:       state_nxt = S_RESULT;
			S_SCAN_COUNT: begin
				if (sts.s2_last) begin
					state_nxt = S_RESULT;
				end
			end
			S_FREE_RD:    state_nxt = S_FREE_WR;
			S_FREE_WR:    state_nxt = S_RESULT;
			S_RESULT: begin
				if (sts.out_free) begin
					state_nxt = S_IDLE;
				end
			end
			default:      state_nxt = S_IDLE;
		endcase
	end

	// datapath commands
	always_comb begin
		ctl       = '0;
		cmd_stall = (state_q != S_IDLE);
		case (state_q)
			S_CLEAR: ctl.clr_wr = 1'b1;
			S_IDLE:  ctl.start = cmd_valid;
			S_DISP: begin
				ctl.set_full  = (cmd_q == CMD_ALLOC) && sts.lim_zero;
				ctl.set_range = (cmd_q == CMD_FREE) && sts.idx_range;
			end
			S_SCAN_ALLOC: begin
				ctl.scan_rd  = !sts.issue_done && !sts.s1_hit;
				ctl.hit_cap  = sts.s1_hit;
				ctl.set_full = !sts.s1_hit && sts.s1_last;
			end
			S_FIND: ctl.find_wr = 1'b1;
			S_SCAN_COUNT: begin
				ctl.scan_rd = !sts.issue_done;
				ctl.acc_en  = 1'b1;
			end
			S_FREE_RD: ctl.free_rd = 1'b1;
			S_FREE_WR: ctl.free_wr = 1'b1;
			S_RESULT:  ctl.load_out = sts.out_free;
			default:   ctl = '0;
		endcase
	end

endmodule

FILE: rtl/bba_dp.sv
// datapath of the bitmap block allocator: bitmap memory, scan pipeline, result register
module bba_dp #(
	parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [12:0]         cfg_data,
	input  logic [11:0]         block_index,
	input  bba_pkg::bba_ctl_t   ctl,
	output bba_pkg::bba_sts_t   sts,
	output bba_pkg::bba_rsp_t   rsp,
	output logic                rsp_valid,
	input  logic                rsp_stall
);
	import bba_pkg::*;

	localparam int NWORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
	localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
	localparam int CW     = ($clog2(MAX_BLOCKS + 1) > 13) ? $clog2(MAX_BLOCKS + 1) : 13;
	localparam int LWW    = CW - WORD_SHIFT;

	// bitmap memory, bit b of word w is block w*64+b, 1 = used
	logic [WORD_BITS-1:0] mem [NWORDS];

	logic [12:0]          nblk_q;
	logic [CW-1:0]        lim_c;
	logic [CW-1:0]        lim_q;
	logic [AW-1:0]        last_word_q;
	logic [11:0]          idx_q;
	logic [AW-1:0]        idx_word;
	logic [AW-1:0]        addr_q;
	logic                 issue_done_q;

	logic                 rd_en;
	logic [AW-1:0]        rd_addr;
	logic                 wr_en;
	logic [AW-1:0]        wr_addr;
	logic [WORD_BITS-1:0] wr_data;

	logic [WORD_BITS-1:0] rdata_s1;
	logic [AW-1:0]        addr_s1;
	logic                 v_s1;
	logic [WORD_BITS-1:0] lim_mask;
	logic [WORD_BITS-1:0] free_mask;

	logic [3:0]           pc_s2 [8];
	logic                 v_s2;
	logic                 last_s2;
	logic [6:0]           pc_sum;
	logic [CW-1:0]        acc_q;

	logic [WORD_BITS-1:0] hit_mask_q;
	logic [WORD_BITS-1:0] hit_data_q;
	logic [AW-1:0]        hit_addr_q;
	logic [7:0]           byte_any;
	logic [2:0]           byte_sel;
	logic [2:0]           bit_sel;
	logic [5:0]           hit_pos;

	logic [1:0]           status_q;
	logic [11:0]          granted_q;
	bba_rsp_t             rsp_q;
	logic                 rsp_valid_q;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nblk_q <= NBLK_RST;
		end else if (cfg_we) begin
			nblk_q <= cfg_data;
		end
	end

	// effective block count, saturated at the bitmap size
	assign lim_c = (CW'(nblk_q) > CW'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS) : CW'(nblk_q);

	// word holding the block to free
	assign idx_word = AW'(idx_q >> WORD_SHIFT);

	// per-command registers latched at accept
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			lim_q       <= lim_c;
			last_word_q <= AW'((lim_c - CW'(1)) >> WORD_SHIFT);
			idx_q       <= block_index;
		end
	end

	// scan address counter, also walks the memory for the clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q       <= '0;
			issue_done_q <= 1'b0;
		end else if (ctl.start) begin
			addr_q       <= '0;
			issue_done_q <= 1'b0;
		end else if (ctl.clr_wr) begin
			addr_q <= addr_q + AW'(1);
		end else if (ctl.scan_rd) begin
			addr_q <= addr_q + AW'(1);
			if (addr_q == last_word_q) begin
				issue_done_q <= 1'b1;
			end
		end
	end

	// memory port selection
	always_comb begin
		rd_en   = ctl.scan_rd || ctl.free_rd;
		rd_addr = ctl.free_rd ? idx_word : addr_q;
		wr_en   = ctl.clr_wr || ctl.find_wr || ctl.free_wr;
		wr_addr = addr_q;
		wr_data = '0;
		if (ctl.find_wr) begin
			wr_addr = hit_addr_q;
			wr_data = hit_data_q | (WORD_BITS'(1) << hit_pos);
		end else if (ctl.free_wr) begin
			wr_addr = idx_word;
			wr_data = rdata_s1 & ~(WORD_BITS'(1) << idx_q[WORD_SHIFT-1:0]);
		end
	end

	// bitmap memory with registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_s1 <= mem[rd_addr];
		end
		addr_s1 <= rd_addr;
	end

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= ctl.scan_rd && !ctl.start;
		end
	end

	// blocks at or past the count never look free
	always_comb begin
		for (int b = 0; b < WORD_BITS; b++) begin
			if (LWW'(addr_s1) < LWW'(lim_q >> WORD_SHIFT)) begin
				lim_mask[b] = 1'b1;
			end else if (LWW'(addr_s1) == LWW'(lim_q >> WORD_SHIFT)) begin
				lim_mask[b] = (6'(b) < lim_q[WORD_SHIFT-1:0]);
			end else begin
				lim_mask[b] = 1'b0;
			end
		end
		free_mask = ~rdata_s1 & lim_mask;
	end

	// stage 2: per-byte free counts
	always_ff @(posedge clk) begin
		for (int k = 0; k < 8; k++) begin
			pc_s2[k] <= popcount8(free_mask[k*8 +: 8]);
		end
		last_s2 <= (addr_s1 == last_word_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1 && !ctl.start;
		end
	end

	// free block accumulator
	always_comb begin
		pc_sum = '0;
		for (int k = 0; k < 8; k++) begin
			pc_sum = pc_sum + 7'(pc_s2[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			acc_q <= '0;
		end else if (ctl.acc_en && v_s2) begin
			acc_q <= acc_q + CW'(pc_sum);
		end
	end

	// capture of the first word with a free block
	always_ff @(posedge clk) begin
		if (ctl.hit_cap) begin
			hit_mask_q <= free_mask;
			hit_data_q <= rdata_s1;
			hit_addr_q <= addr_s1;
		end
	end

	// lowest free bit: byte first, then bit within it
	always_comb begin
		for (int k = 0; k < 8; k++) begin
			byte_any[k] = |hit_mask_q[k*8 +: 8];
		end
		byte_sel = lowest8(byte_any);
		bit_sel  = lowest8(hit_mask_q[byte_sel*8 +: 8]);
		hit_pos  = {byte_sel, bit_sel};
	end

	// result fields
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			status_q  <= STAT_OK;
			granted_q <= '0;
		end else begin
			if (ctl.set_full) begin
				status_q <= STAT_FULL;
			end
			if (ctl.set_range) begin
				status_q <= STAT_RANGE;
			end
			if (ctl.find_wr) begin
				granted_q <= 12'({hit_addr_q, hit_pos});
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			rsp_q.status        <= status_q;
			rsp_q.granted_index <= granted_q;
			rsp_q.free_total    <= 13'(acc_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ctl.load_out) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

	// status to the controller
	always_comb begin
		sts.clr_last   = (addr_q == AW'(NWORDS - 1));
		sts.issue_done = issue_done_q;
		sts.s1_hit     = v_s1 && (|free_mask);
		sts.s1_last    = v_s1 && (addr_s1 == last_word_q);
		sts.s2_last    = v_s2 && last_s2;
		sts.lim_zero   = (lim_q == '0);
		sts.idx_range  = (CW'(idx_q) >= lim_q);
		sts.out_free   = !rsp_valid_q || !rsp_stall;
	end

	// only one memory write source at a time
	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl.clr_wr, ctl.find_wr, ctl.free_wr}))
		else $error("more than one bitmap write source");

	// a captured hit word holds at least one free block
	a_hit_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.hit_cap |=> (|hit_mask_q))
		else $error("captured hit word has no free block");

	// a result is never loaded over one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load_out |-> (!rsp_valid_q || !rsp_stall))
		else $error("result register overwritten while stalled");

	// reads never overlap writes
	a_rd_wr_apart: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> !wr_en)
		else $error("bitmap read and write in the same cycle");

endmodule
